// ===== hdl/foq_pkg.sv =====
`default_nettype none
package foq_pkg;

  // Field widths of the request and response channels
  localparam int CMD_W  = 2;
  localparam int DATA_W = 32;
  localparam int KEY_W  = 32;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 7;

  // Register port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_ORDERED_MODE = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_PEEK = 2'd2,
    CMD_LEN  = 2'd3
  } foq_cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } foq_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SH_RD,
    S_SH_WR,
    S_INS,
    S_RESP
  } foq_state_t;

  typedef struct packed {
    foq_status_t       status;
    logic [DATA_W-1:0] data_out;
    logic [OCC_W-1:0]  occupancy;
  } foq_rsp_t;

endpackage
`default_nettype wire

// ===== hdl/foq_if.sv =====
`default_nettype none
// Request channel: one command with its entry payload
interface foq_req_if;
  logic                         valid;
  logic                         ready;
  logic [foq_pkg::CMD_W-1:0]    command;
  logic [foq_pkg::DATA_W-1:0]   data;
  logic [foq_pkg::KEY_W-1:0]    key;

  modport source (output valid, command, data, key, input ready);
  modport sink   (input valid, command, data, key, output ready);
endinterface

// Response channel: one result per command
interface foq_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [foq_pkg::STAT_W-1:0]   status;
  logic [foq_pkg::DATA_W-1:0]   data_out;
  logic [foq_pkg::OCC_W-1:0]    occupancy;

  modport source (output valid, status, data_out, occupancy, input ready);
  modport sink   (input valid, status, data_out, occupancy, output ready);
endinterface
`default_nettype wire

// ===== hdl/fifo_or_key_ordered_queue.sv =====
// Read length and FIFO enqueue go straight to the response; peek and dequeue first read the
// head entry; ordered enqueue compares entries from the head, moves the later ones a slot
// toward the tail and then writes the new entry. One command is worked at a time; the next
// request is taken once the previous result sits in the output register. One read and one
// write port serve every move. Reset (synchronous, rst_n low) empties the queue and
// clears ordered mode; no sweep.
`default_nettype none
module fifo_or_key_ordered_queue #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32,
  parameter int KEY_WIDTH  = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  foq_req_if.sink                            in_chan,
  foq_rsp_if.source                          out_chan,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [foq_pkg::CFG_AW-1:0]    cfg_paddr,
  input  wire logic [foq_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic      [foq_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                               cfg_pready
);

  // Stored widths: the channel fields are cut to the configured widths
  localparam int DS = (DATA_WIDTH < foq_pkg::DATA_W) ? DATA_WIDTH : foq_pkg::DATA_W;
  localparam int KS = (KEY_WIDTH < foq_pkg::KEY_W) ? KEY_WIDTH : foq_pkg::KEY_W;
  localparam int EW = DS + KS;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // Entry memory: key in the upper bits, data in the lower bits
  logic [EW-1:0] mem_q [CAPACITY];
  logic [EW-1:0] mem_rdata_r;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [EW-1:0] mem_wdata;

  foq_pkg::foq_state_t state_r, state_nxt;
  foq_pkg::foq_cmd_t   cmd_r, cmd_nxt;
  logic [DS-1:0]       data_r, data_nxt;
  logic [KS-1:0]       key_r, key_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [AW-1:0]       head_r, head_nxt;
  logic [CW-1:0]       pos_r, pos_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic                mode_r;
  foq_pkg::foq_rsp_t   rsp_r, rsp_nxt;
  foq_pkg::foq_rsp_t   out_r;
  logic                out_valid_r;

  logic                in_take;
  logic                out_free;
  logic                full;
  logic                empty;
  logic [KS-1:0]       rd_key;
  logic [DS-1:0]       rd_data;
  logic [CW-1:0]       count_inc;
  logic [CW-1:0]       count_dec;

  // Map a queue position to a memory slot, relative to the head
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                            input logic [CW-1:0] p);
    logic [AW:0] sum;
    begin
      sum = {1'b0, head} + {1'b0, p[AW-1:0]};
      if (sum >= (AW+1)'(CAPACITY)) sum = sum - (AW+1)'(CAPACITY);
      slot_of = sum[AW-1:0];
    end
  endfunction

  assign in_take   = in_chan.valid && in_chan.ready;
  assign out_free  = !out_valid_r || out_chan.ready;
  assign full      = (count_r == CW'(CAPACITY));
  assign empty     = (count_r == '0);
  assign rd_key    = mem_rdata_r[EW-1:DS];
  assign rd_data   = mem_rdata_r[DS-1:0];
  assign count_inc = count_r + CW'(1);
  assign count_dec = count_r - CW'(1);

  assign in_chan.ready = (state_r == foq_pkg::S_IDLE);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      foq_pkg::S_IDLE: begin
        if (in_take) begin
          unique case (foq_pkg::foq_cmd_t'(in_chan.command))
            foq_pkg::CMD_ENQ: begin
              if (!full && mode_r) state_nxt = foq_pkg::S_SCAN_RD;
              else                 state_nxt = foq_pkg::S_RESP;
            end
            foq_pkg::CMD_DEQ, foq_pkg::CMD_PEEK: begin
              if (empty) state_nxt = foq_pkg::S_RESP;
              else       state_nxt = foq_pkg::S_HEAD;
            end
            foq_pkg::CMD_LEN: state_nxt = foq_pkg::S_RESP;
            default:          state_nxt = foq_pkg::S_RESP;
          endcase
        end
      end
      foq_pkg::S_HEAD:     state_nxt = foq_pkg::S_RESP;
      foq_pkg::S_SCAN_RD: begin
        if (pos_r == count_r) state_nxt = foq_pkg::S_SH_RD;
        else                  state_nxt = foq_pkg::S_SCAN_CHK;
      end
      foq_pkg::S_SCAN_CHK: begin
        if (key_r >= rd_key) state_nxt = foq_pkg::S_SCAN_RD;
        else                 state_nxt = foq_pkg::S_SH_RD;
      end
      foq_pkg::S_SH_RD: begin
        if (idx_r == pos_r) state_nxt = foq_pkg::S_INS;
        else                state_nxt = foq_pkg::S_SH_WR;
      end
      foq_pkg::S_SH_WR:    state_nxt = foq_pkg::S_SH_RD;
      foq_pkg::S_INS:      state_nxt = foq_pkg::S_RESP;
      foq_pkg::S_RESP: begin
        if (out_free) state_nxt = foq_pkg::S_IDLE;
      end
      default:             state_nxt = foq_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    cmd_nxt   = cmd_r;
    data_nxt  = data_r;
    key_nxt   = key_r;
    count_nxt = count_r;
    head_nxt  = head_r;
    pos_nxt   = pos_r;
    idx_nxt   = idx_r;
    rsp_nxt   = rsp_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = slot_of(head_r, idx_r);
    mem_raddr = head_r;
    mem_wdata = {key_r, data_r};
    unique case (state_r)
      foq_pkg::S_IDLE: begin
        if (in_take) begin
          cmd_nxt  = foq_pkg::foq_cmd_t'(in_chan.command);
          data_nxt = in_chan.data[DS-1:0];
          key_nxt  = in_chan.key[KS-1:0];
          pos_nxt  = '0;
          rsp_nxt  = '{status: foq_pkg::ST_OK, data_out: '0,
                       occupancy: foq_pkg::OCC_W'(count_r)};
          unique case (foq_pkg::foq_cmd_t'(in_chan.command))
            foq_pkg::CMD_ENQ: begin
              if (full) begin
                rsp_nxt.status = foq_pkg::ST_FULL;
              end else if (!mode_r) begin
                // Append at the tail in one write
                mem_we            = 1'b1;
                mem_waddr         = slot_of(head_r, count_r);
                mem_wdata         = {in_chan.key[KS-1:0], in_chan.data[DS-1:0]};
                count_nxt         = count_inc;
                rsp_nxt.occupancy = foq_pkg::OCC_W'(count_inc);
              end
            end
            foq_pkg::CMD_DEQ, foq_pkg::CMD_PEEK: begin
              if (empty) rsp_nxt.status = foq_pkg::ST_EMPTY;
              else       mem_re = 1'b1;
            end
            foq_pkg::CMD_LEN: ;
            default: ;
          endcase
        end
      end
      foq_pkg::S_HEAD: begin
        rsp_nxt.data_out = foq_pkg::DATA_W'(rd_data);
        if (cmd_r == foq_pkg::CMD_DEQ) begin
          head_nxt          = slot_of(head_r, CW'(1));
          count_nxt         = count_dec;
          rsp_nxt.occupancy = foq_pkg::OCC_W'(count_dec);
        end
      end
      foq_pkg::S_SCAN_RD: begin
        if (pos_r == count_r) begin
          idx_nxt = count_r;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = slot_of(head_r, pos_r);
        end
      end
      foq_pkg::S_SCAN_CHK: begin
        // Advance past entries whose key is not greater than the new key
        if (key_r >= rd_key) pos_nxt = pos_r + CW'(1);
        else                 idx_nxt = count_r;
      end
      foq_pkg::S_SH_RD: begin
        if (idx_r != pos_r) begin
          mem_re    = 1'b1;
          mem_raddr = slot_of(head_r, idx_r - CW'(1));
        end
      end
      foq_pkg::S_SH_WR: begin
        // Move one entry a slot toward the tail
        mem_we    = 1'b1;
        mem_waddr = slot_of(head_r, idx_r);
        mem_wdata = mem_rdata_r;
        idx_nxt   = idx_r - CW'(1);
      end
      foq_pkg::S_INS: begin
        mem_we            = 1'b1;
        mem_waddr         = slot_of(head_r, pos_r);
        mem_wdata         = {key_r, data_r};
        count_nxt         = count_inc;
        rsp_nxt.occupancy = foq_pkg::OCC_W'(count_inc);
      end
      foq_pkg::S_RESP: ;
      default: ;
    endcase
  end

  // Entry memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_r <= mem_q[mem_raddr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= foq_pkg::S_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      head_r  <= head_nxt;
      if (state_r == foq_pkg::S_RESP && out_free) out_valid_r <= 1'b1;
      else if (out_chan.ready)                    out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    data_r <= data_nxt;
    key_r  <= key_nxt;
    pos_r  <= pos_nxt;
    idx_r  <= idx_nxt;
    rsp_r  <= rsp_nxt;
    if (state_r == foq_pkg::S_RESP && out_free) out_r <= rsp_r;
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.status    = out_r.status;
  assign out_chan.data_out  = out_r.data_out;
  assign out_chan.occupancy = out_r.occupancy;

  // Register port: word index in paddr[2]
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == foq_pkg::REG_ORDERED_MODE) begin
      mode_r <= cfg_pwdata[0];
    end
  end

  assign cfg_pready = 1'b1;

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == foq_pkg::REG_ORDERED_MODE) cfg_prdata[0] = mode_r;
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("occupancy above capacity");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, head_r} < (AW+1)'(CAPACITY))
    else $error("head slot out of range");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == foq_pkg::S_INS) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("ordered insert did not grow the queue by one");

  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == foq_pkg::S_SH_RD || state_r == foq_pkg::S_SH_WR) |->
      (idx_r >= pos_r && idx_r <= count_r && !full))
    else $error("shift index outside insert range");
`endif

endmodule
`default_nettype wire
